/* rtl/gocd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gocd_pkg: shared definitions for the grid obstacle cross dilation block
// Sizes, register map, command codes and line buffer types.
// ----------------------------------------------------------------------------
package gocd_pkg;

	// grid geometry
	localparam int MAX_COLS  = 256;
	localparam int COL_W     = $clog2(MAX_COLS);   // column index
	localparam int CNT_W     = COL_W + 1;          // holds MAX_COLS itself
	localparam int ROW_W     = 16;
	localparam int OUT_COL_W = 8;

	// configuration registers
	localparam int ROWS_CFG_W = 16;
	localparam int COLS_CFG_W = 9;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'(150);
	localparam logic [COLS_CFG_W-1:0] COLS_RST = COLS_CFG_W'(150);

	// APB port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// input command codes
	typedef enum logic {
		CMD_CELL  = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	// one line buffer entry: the column's value in the last two input rows
	typedef struct packed {
		logic prior;
		logic older;
	} lb_word_t;

	// line buffer write port
	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
		lb_word_t         data;
	} lb_wr_t;

endpackage

/* rtl/gocd_linebuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gocd_linebuf: two-row line buffer memory
// One entry per column holding the last two input rows. Two synchronous read
// ports, one write port, with forwarding of a write that lands on the same
// edge as a read of the same entry.
// ----------------------------------------------------------------------------
module gocd_linebuf (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [gocd_pkg::COL_W-1:0] rd_addr_a,
	input  logic [gocd_pkg::COL_W-1:0] rd_addr_b,
	input  gocd_pkg::lb_wr_t          wr,
	output gocd_pkg::lb_word_t        rd_a,
	output gocd_pkg::lb_word_t        rd_b
);

	gocd_pkg::lb_word_t mem [gocd_pkg::MAX_COLS];

	gocd_pkg::lb_word_t rdata_a_q;
	gocd_pkg::lb_word_t rdata_b_q;
	gocd_pkg::lb_word_t fwd_data_q;
	logic               fwd_a_q;
	logic               fwd_b_q;

	// write, read, and note a collision with the write of the same edge
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rdata_a_q  <= mem[rd_addr_a];
			rdata_b_q  <= mem[rd_addr_b];
			fwd_a_q    <= wr.en && (wr.addr == rd_addr_a);
			fwd_b_q    <= wr.en && (wr.addr == rd_addr_b);
			fwd_data_q <= wr.data;
		end
	end

	assign rd_a = fwd_a_q ? fwd_data_q : rdata_a_q;
	assign rd_b = fwd_b_q ? fwd_data_q : rdata_b_q;

endmodule

/* rtl/grid_obstacle_cross_dilation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_obstacle_cross_dilation: grows obstacles of a raster grid by one cell
// Cross-shaped 3x3 dilation of a binary occupancy grid streamed in raster
// order, using a two-row line buffer memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one beat per cell, cmd selects a grid
//   cell (blocked_in) or a drain tick. Output channel (out_valid/out_stall):
//   one beat per dilated cell with its row, column and a frame_last flag.
//   Cells of row r emit row r-1, so row 0 emits nothing; after the last row,
//   drain ticks emit that row one cell per tick. A drain with no pending row
//   is dropped. grid_rows/grid_cols are set over the APB port while idle.
// Throughput:
//   One beat per clock on both sides while the output is not stalled. A result
//   passes through the memory read, then the output register. The rate is set by
//   the line buffer: two reads and one write per cycle.
// Reset:
//   Counters clear, the output is empty, registers take 150 x 150. Line
//   buffer contents are not cleared; row 0 of each frame fills them.
// Stall:
//   While out_stall holds a result, one more item with a result is taken into
//   the memory stage (items with none pass); then in_stall follows out_stall.
// ----------------------------------------------------------------------------
module grid_obstacle_cross_dilation (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gocd_pkg::APB_AW-1:0]    paddr,
	input  logic [gocd_pkg::APB_DW-1:0]    pwdata,
	output logic [gocd_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	// input cells
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic                          blocked_in,
	// output cells
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          blocked_out,
	output logic [gocd_pkg::ROW_W-1:0]     out_row,
	output logic [gocd_pkg::OUT_COL_W-1:0] out_col,
	output logic                          frame_last
);

	localparam int ROW_W = gocd_pkg::ROW_W;
	localparam int COL_W = gocd_pkg::COL_W;
	localparam int CNT_W = gocd_pkg::CNT_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [gocd_pkg::ROWS_CFG_W-1:0] rows_q;
	logic [gocd_pkg::COLS_CFG_W-1:0] cols_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gocd_pkg::ROWS_RST;
			cols_q <= gocd_pkg::COLS_RST;
		end else if (cfg_wr) begin
			unique case (gocd_pkg::reg_idx_t'(paddr[2])) 
				gocd_pkg::REG_ROWS: rows_q <= pwdata[gocd_pkg::ROWS_CFG_W-1:0];
				gocd_pkg::REG_COLS: cols_q <= pwdata[gocd_pkg::COLS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (gocd_pkg::reg_idx_t'(paddr[2]))
			gocd_pkg::REG_ROWS: prdata = gocd_pkg::APB_DW'(rows_q);
			gocd_pkg::REG_COLS: prdata = gocd_pkg::APB_DW'(cols_q);
			default:            prdata = '0;
		endcase
	end

	// effective grid size: zero acts as one, columns clip to the buffer depth
	logic [ROW_W-1:0] nr_eff;
	logic [CNT_W-1:0] nc_eff;

	assign nr_eff = (rows_q == '0) ? ROW_W'(1) : rows_q;

	always_comb begin
		if (cols_q == '0) begin
			nc_eff = CNT_W'(1);
		end else if (32'(cols_q) > gocd_pkg::MAX_COLS) begin
			nc_eff = CNT_W'(gocd_pkg::MAX_COLS);
		end else begin
			nc_eff = CNT_W'(cols_q);
		end
	end

	// ------------------------------------------------------------------
	// Input stage: raster counters and line buffer read
	// ------------------------------------------------------------------
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] in_col_q;
	logic [COL_W-1:0] drain_col_q;

	logic             accept;
	logic             pending;
	logic             is_drain;
	logic [ROW_W-1:0] cell_row;
	logic [COL_W-1:0] cell_col;
	logic [COL_W-1:0] cur_col;
	logic [CNT_W-1:0] col_inc;
	logic             row_end;
	logic             has_res;
	logic [ROW_W-1:0] orow;

	assign accept   = in_valid && !in_stall;
	assign pending  = in_row_q >= nr_eff;
	assign is_drain = (gocd_pkg::cmd_t'(cmd) == gocd_pkg::CMD_DRAIN);

	// a cell arriving with a drain pending opens a new frame
	assign cell_row = pending ? '0 : in_row_q;
	assign cell_col = pending ? '0 : in_col_q;
	assign cur_col  = is_drain ? drain_col_q : cell_col;
	assign col_inc  = CNT_W'(cur_col) + CNT_W'(1);
	assign row_end  = col_inc >= nc_eff;
	assign has_res  = is_drain ? pending : (cell_row != '0);
	assign orow     = is_drain ? (nr_eff - ROW_W'(1)) : (cell_row - ROW_W'(1));

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q    <= '0;
			in_col_q    <= '0;
			drain_col_q <= '0;
		end else if (accept) begin
			if (is_drain) begin
				if (pending) begin
					if (row_end) begin
						in_row_q    <= '0;
						in_col_q    <= '0;
						drain_col_q <= '0;
					end else begin
						drain_col_q <= col_inc[COL_W-1:0];
					end
				end
			end else begin
				drain_col_q <= pending ? '0 : drain_col_q;
				if (row_end) begin
					in_row_q    <= cell_row + ROW_W'(1);
					in_col_q    <= '0;
					drain_col_q <= '0;
				end else begin
					in_row_q <= cell_row;
					in_col_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Memory stage
	// ------------------------------------------------------------------
	logic             valid_s1;
	logic             res_s1;
	logic             wr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] orow_s1;
	logic             below_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic             go_s1;
	logic             leave_s1;

	assign go_s1    = !(res_s1 && out_valid_q && out_stall);
	assign leave_s1 = valid_s1 && go_s1;
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1   <= has_res;
			wr_s1    <= !is_drain;
			col_s1   <= cur_col;
			orow_s1  <= orow;
			below_s1 <= !is_drain && blocked_in;
			last_s1  <= is_drain && row_end;
		end
	end

	gocd_pkg::lb_wr_t   lb_wr;
	gocd_pkg::lb_word_t rd_a;
	gocd_pkg::lb_word_t rd_b;

	gocd_linebuf u_linebuf (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (cur_col),
		.rd_addr_b (col_inc[COL_W-1:0]),
		.wr        (lb_wr),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	// write back this column: new row on top, previous row below it
	always_comb begin
		lb_wr.en         = leave_s1 && wr_s1;
		lb_wr.addr       = col_s1;
		lb_wr.data.prior = below_s1;
		lb_wr.data.older = rd_a.prior;
	end

	// left neighbor: prior-row value read for the previous column
	logic prev_prior_q;

	always_ff @(posedge clk) begin
		if (leave_s1 && (wr_s1 || res_s1)) begin
			prev_prior_q <= rd_a.prior;
		end
	end

	// neighbor qualification: a neighbor marks only from the interior
	logic             col_in;
	logic             row_in;
	logic             up_ok;
	logic             down_ok;
	logic             left_ok;
	logic             right_ok;
	logic [ROW_W:0]   orow_x;
	logic [ROW_W:0]   nr_x;
	logic [CNT_W-1:0] col_x;
	logic             blk;

	assign orow_x   = (ROW_W+1)'(orow_s1);
	assign nr_x     = (ROW_W+1)'(nr_eff);
	assign col_x    = CNT_W'(col_s1);

	assign col_in   = (col_s1 != '0) && ((col_x + CNT_W'(1)) < nc_eff);
	assign row_in   = (orow_s1 != '0) && ((orow_x + (ROW_W+1)'(1)) < nr_x);
	assign up_ok    = (orow_s1 >= ROW_W'(2)) && (orow_s1 < nr_eff) && col_in;
	assign down_ok  = ((orow_x + (ROW_W+1)'(2)) < nr_x) && col_in;
	assign left_ok  = row_in && (col_s1 >= COL_W'(2)) && (col_x < nc_eff);
	assign right_ok = row_in && ((col_x + CNT_W'(2)) < nc_eff);

	assign blk = rd_a.prior
		| (up_ok    && rd_a.older)
		| (down_ok  && below_s1)
		| (left_ok  && prev_prior_q)
		| (right_ok && rd_b.prior);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic                    blocked_q;
	logic [ROW_W-1:0]        out_row_q;
	logic [gocd_pkg::OUT_COL_W-1:0] out_col_q;
	logic                    frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave_s1 && res_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_s1 && res_s1) begin
			blocked_q    <= blk;
			out_row_q    <= orow_s1;
			out_col_q    <= col_s1[gocd_pkg::OUT_COL_W-1:0];
			frame_last_q <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign blocked_out = blocked_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign frame_last  = frame_last_q;

endmodule

/* rtl/gocd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gocd_checker: port-level checks for grid_obstacle_cross_dilation
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gocd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          blocked_out,
	input logic [gocd_pkg::ROW_W-1:0]     out_row,
	input logic [gocd_pkg::OUT_COL_W-1:0] out_col,
	input logic                          frame_last
);

	// input is held back only by a result stuck at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output beat");

	// a new result follows an input beat through the memory stage and output register
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output beat without a matching input beat");

	// a stalled output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(blocked_out)
			&& $stable(out_row) && $stable(out_col) && $stable(frame_last)))
		else $error("stalled output beat changed");

endmodule

bind grid_obstacle_cross_dilation gocd_checker u_gocd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.blocked_out (blocked_out),
	.out_row     (out_row),
	.out_col     (out_col),
	.frame_last  (frame_last)
);
